// ===== hw/rtl/rcceh_pkg.sv =====
// Shared constants and types for the capped cylinder end-cap hit block.
// Used by rcceh_cap and ray_capped_cylinder_endcap_hit; no dependencies.
`default_nettype none
package rcceh_pkg;

  localparam int CW_DEF     = 21;
  localparam int Q_SHIFT    = 19;
  localparam int RAD_W      = 20;
  localparam int OUT_DIST_W = 21;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOP_CENTER    = 3'd0,
    REG_BOTTOM_CENTER = 3'd1,
    REG_AXIS_UNIT     = 3'd2,
    REG_CAP_RADIUS    = 3'd3,
    REG_PAR_THRESHOLD = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } cap_flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rcceh_cap.sv =====
// Pipelined ray / cap disc test for one cap: plane distance, divider, range and radius checks.
// Depends on rcceh_pkg.
`default_nettype none
module rcceh_cap
  import rcceh_pkg::*;
#(
  parameter int CW = CW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [8*CW-1:0]       in_ray,
  input  logic [3*CW-1:0]       ctr,
  input  logic [3*CW-1:0]       ax,
  input  logic [RAD_W-1:0]      rad,
  input  logic [RAD_W-1:0]      thr,
  output cap_flags_t            res_flags,
  output logic signed [CW-1:0]  res_t
);

  localparam int RAYW = 8*CW;
  localparam int DENW = 2*CW + 2;
  localparam int NUMW = 2*CW + 3;
  localparam int DW   = 2*CW;
  localparam int NW   = 2*CW + 1;
  localparam int XW   = NW + Q_SHIFT;
  localparam int LIMW = RAD_W + Q_SHIFT;
  localparam int DS   = CW + 1;
  localparam int PW   = 2*CW - Q_SHIFT;
  localparam int QW   = ((PW > CW) ? PW : CW) + 2;
  localparam int SQW  = 2*QW;
  localparam int SAW  = SQW + 2;
  localparam int RRW  = 2*RAD_W;
  localparam int SW   = (SAW > RRW) ? SAW : RRW;

  logic signed [CW-1:0] org0 [3];
  logic signed [CW-1:0] dir0 [3];
  logic signed [CW-1:0] ctr_c [3];
  logic signed [CW-1:0] ax_c [3];

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign org0[i]  = in_ray[i*CW +: CW];
    assign dir0[i]  = in_ray[(3+i)*CW +: CW];
    assign ctr_c[i] = ctr[i*CW +: CW];
    assign ax_c[i]  = ax[i*CW +: CW];
  end

  // Stage 1: products.
  logic                   v1_r;
  logic [RAYW-1:0]        ray1_r;
  logic signed [DW-1:0]   pd1_r [3];
  logic signed [NW-1:0]   pn1_r [3];
  logic signed [DW-1:0]   pd1_nxt [3];
  logic signed [NW-1:0]   pn1_nxt [3];
  logic signed [CW:0]     diff [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]    = {ctr_c[i][CW-1], ctr_c[i]} - {org0[i][CW-1], org0[i]};
      pd1_nxt[i] = dir0[i] * ax_c[i];
      pn1_nxt[i] = diff[i] * ax_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ray1_r <= in_ray;
    for (int i = 0; i < 3; i++) begin
      pd1_r[i] <= pd1_nxt[i];
      pn1_r[i] <= pn1_nxt[i];
    end
  end

  // Stage 2: dot products.
  logic                   v2_r;
  logic [RAYW-1:0]        ray2_r;
  logic signed [DENW-1:0] den2_r, den2_nxt;
  logic signed [NUMW-1:0] num2_r, num2_nxt;

  assign den2_nxt = pd1_r[0] + pd1_r[1] + pd1_r[2];
  assign num2_nxt = pn1_r[0] + pn1_r[1] + pn1_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    ray2_r <= ray1_r;
    den2_r <= den2_nxt;
    num2_r <= num2_nxt;
  end

  // Stage 3: magnitudes, parallel test and divider setup.
  logic [DENW-1:0] mag_den_w;
  logic [NUMW-1:0] mag_num_w;
  logic [DW-1:0]   mag_d;
  logic [NW-1:0]   mag_n;
  logic [XW-1:0]   xdiv;
  logic [XW-1:0]   xhigh;
  logic [LIMW-1:0] lim;
  logic            par_miss;
  logic            ovf;

  logic            dv_r [DS+1];
  logic            dm_r [DS+1];
  logic            dn_r [DS+1];
  logic [DW-1:0]   dr_r [DS+1];
  logic [DW-1:0]   dd_r [DS+1];
  logic [CW:0]     dx_r [DS+1];
  logic [CW:0]     dq_r [DS+1];
  logic [RAYW-1:0] dray_r [DS+1];

  always_comb begin
    mag_den_w = (den2_r < 0) ? DENW'(-den2_r) : DENW'(den2_r);
    mag_num_w = (num2_r < 0) ? NUMW'(-num2_r) : NUMW'(num2_r);
    mag_d     = mag_den_w[DW-1:0];
    mag_n     = mag_num_w[NW-1:0];
    xdiv      = {mag_n, {Q_SHIFT{1'b0}}};
    xhigh     = xdiv >> (CW + 1);
    lim       = {thr, {Q_SHIFT{1'b0}}};
    par_miss  = (den2_r == 0) || (XW'(mag_d) < XW'(lim));
    ovf       = xhigh >= XW'(mag_d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dm_r[0]   <= par_miss | ovf;
    dn_r[0]   <= den2_r[DENW-1] ^ num2_r[NUMW-1];
    dr_r[0]   <= xhigh[DW-1:0];
    dd_r[0]   <= mag_d;
    dx_r[0]   <= xdiv[CW:0];
    dq_r[0]   <= '0;
    dray_r[0] <= ray2_r;
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [DW:0] rs;
    logic [DW:0] rsub;
    logic        ge;
    logic [CW:0] qn;

    always_comb begin
      rs   = {dr_r[k], dx_r[k][CW-k]};
      rsub = rs - {1'b0, dd_r[k]};
      ge   = rs >= {1'b0, dd_r[k]};
      qn   = dq_r[k];
      qn[CW-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dm_r[k+1]   <= dm_r[k];
      dn_r[k+1]   <= dn_r[k];
      dr_r[k+1]   <= ge ? rsub[DW-1:0] : rs[DW-1:0];
      dd_r[k+1]   <= dd_r[k];
      dx_r[k+1]   <= dx_r[k];
      dq_r[k+1]   <= qn;
      dray_r[k+1] <= dray_r[k];
    end
  end

  // Stage T: signed distance and interval test.
  logic signed [CW+1:0] qs, tq, dmin_e, dmax_e;
  logic signed [CW-1:0] dmin_c, dmax_c;
  logic                 in_rng;
  logic                 vt_r, mt_r;
  logic signed [CW-1:0] tt_r;
  logic [RAYW-1:0]      rayt_r;

  assign dmin_c = dray_r[DS][6*CW +: CW];
  assign dmax_c = dray_r[DS][7*CW +: CW];

  always_comb begin
    qs     = {1'b0, dq_r[DS]};
    tq     = dn_r[DS] ? -qs : qs;
    dmin_e = dmin_c;
    dmax_e = dmax_c;
    in_rng = (tq > dmin_e) && (tq < dmax_e);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else begin
      vt_r <= dv_r[DS];
    end
  end

  always_ff @(posedge clk) begin
    mt_r   <= dm_r[DS] | ~in_rng;
    tt_r   <= tq[CW-1:0];
    rayt_r <= dray_r[DS];
  end

  // Stage M: direction times distance.
  logic signed [CW-1:0] dir_t [3];
  logic signed [DW-1:0] pm_r [3];
  logic signed [DW-1:0] pm_nxt [3];
  logic                 vm_r, mm_r;
  logic signed [CW-1:0] tm_r;
  logic [RAYW-1:0]      raym_r;

  for (genvar i = 0; i < 3; i++) begin : g_dirt
    assign dir_t[i] = rayt_r[(3+i)*CW +: CW];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pm_nxt[i] = dir_t[i] * tt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else begin
      vm_r <= vt_r;
    end
  end

  always_ff @(posedge clk) begin
    mm_r   <= mt_r;
    tm_r   <= tt_r;
    raym_r <= rayt_r;
    for (int i = 0; i < 3; i++) begin
      pm_r[i] <= pm_nxt[i];
    end
  end

  // Stage Q: hit point relative to the cap centre.
  logic signed [CW-1:0] org_m [3];
  logic signed [PW-1:0] ps [3];
  logic signed [QW-1:0] qq_nxt [3];
  logic signed [QW-1:0] qq_r [3];
  logic                 vq_r, mq_r;
  logic signed [CW-1:0] tq_r;

  for (genvar i = 0; i < 3; i++) begin : g_orgm
    assign org_m[i] = raym_r[i*CW +: CW];
    assign ps[i]    = $signed(pm_r[i][DW-1:Q_SHIFT]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qq_nxt[i] = QW'(org_m[i]) + QW'(ps[i]) - QW'(ctr_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else begin
      vq_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    mq_r <= mm_r;
    tq_r <= tm_r;
    for (int i = 0; i < 3; i++) begin
      qq_r[i] <= qq_nxt[i];
    end
  end

  // Stage S: squares.
  logic signed [SQW-1:0] sq_nxt [3];
  logic [SQW-1:0]        sq_r [3];
  logic [RRW-1:0]        r2_r;
  logic                  vs_r, ms_r;
  logic signed [CW-1:0]  ts_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = qq_r[i] * qq_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else begin
      vs_r <= vq_r;
    end
  end

  always_ff @(posedge clk) begin
    ms_r <= mq_r;
    ts_r <= tq_r;
    r2_r <= rad * rad;
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= sq_nxt[i];
    end
  end

  // Stage C: radius test.
  logic [SW-1:0] len2;
  logic          in_rad;
  cap_flags_t    flags_r;
  logic signed [CW-1:0] tc_r;

  always_comb begin
    len2   = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
    in_rad = len2 <= SW'(r2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r.valid <= vs_r;
      flags_r.hit   <= vs_r & ~ms_r & in_rad;
    end
  end

  always_ff @(posedge clk) begin
    tc_r <= ts_r;
  end

  assign res_flags = flags_r;
  assign res_t     = tc_r;

endmodule
`default_nettype wire

// ===== hw/rtl/ray_capped_cylinder_endcap_hit.sv =====
// Top level of the capped cylinder end-cap hit block: configuration registers,
// input register, two cap pipelines and the nearer-hit select. Depends on rcceh_pkg, rcceh_cap.
//
// Usage: a ray beat is taken at a rising edge where start is high and busy is low.
// busy is never raised, so one ray can be taken on every cycle.
// Configuration is written through cfg_we, cfg_index and cfg_wdata with no wait state;
// the user must write it only while no ray is in flight; the block does not enforce this.
// Each ray gives exactly one result beat: out_valid is high for one cycle with
// out_hit and out_hit_distance; throughput is one beat per cycle.
// The restoring divider, one quotient bit per stage, sits between the dot product stages
// and the distance, radius and select stages.
// The receiver cannot stall; results are never held.
// Reset clears all valid bits and the registers: the centres, axis and radius go to
// zero and the parallel threshold to one.
// A miss reports a distance of zero; on equal distances the bottom cap is reported.
`default_nettype none
module ray_capped_cylinder_endcap_hit
  import rcceh_pkg::*;
#(
  parameter int CW = CW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [CW-1:0]         in_origin_x,
  input  logic signed [CW-1:0]         in_origin_y,
  input  logic signed [CW-1:0]         in_origin_z,
  input  logic signed [CW-1:0]         in_dir_x,
  input  logic signed [CW-1:0]         in_dir_y,
  input  logic signed [CW-1:0]         in_dir_z,
  input  logic signed [CW-1:0]         in_dist_min,
  input  logic signed [CW-1:0]         in_dist_max,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic signed [OUT_DIST_W-1:0] out_hit_distance,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [3*CW-1:0]              cfg_wdata
);

  localparam int LAT = CW + 11;

  logic [3*CW-1:0]  top_center_r, bottom_center_r, axis_unit_r;
  logic [RAD_W-1:0] cap_radius_r, par_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_center_r    <= '0;
      bottom_center_r <= '0;
      axis_unit_r     <= '0;
      cap_radius_r    <= '0;
      par_thr_r       <= RAD_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TOP_CENTER:    top_center_r    <= cfg_wdata;
        REG_BOTTOM_CENTER: bottom_center_r <= cfg_wdata;
        REG_AXIS_UNIT:     axis_unit_r     <= cfg_wdata;
        REG_CAP_RADIUS:    cap_radius_r    <= cfg_wdata[RAD_W-1:0];
        REG_PAR_THRESHOLD: par_thr_r       <= cfg_wdata[RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy = 1'b0;

  logic            v0_r;
  logic [8*CW-1:0] ray0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    ray0_r <= {in_dist_max, in_dist_min, in_dir_z, in_dir_y, in_dir_x,
               in_origin_z, in_origin_y, in_origin_x};
  end

  cap_flags_t           top_flags, bot_flags;
  logic signed [CW-1:0] top_t, bot_t;

  rcceh_cap #(.CW(CW)) u_cap_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v0_r),
    .in_ray    (ray0_r),
    .ctr       (top_center_r),
    .ax        (axis_unit_r),
    .rad       (cap_radius_r),
    .thr       (par_thr_r),
    .res_flags (top_flags),
    .res_t     (top_t)
  );

  rcceh_cap #(.CW(CW)) u_cap_bot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v0_r),
    .in_ray    (ray0_r),
    .ctr       (bottom_center_r),
    .ax        (axis_unit_r),
    .rad       (cap_radius_r),
    .thr       (par_thr_r),
    .res_flags (bot_flags),
    .res_t     (bot_t)
  );

  logic                         out_valid_r, out_hit_r;
  logic signed [OUT_DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic signed [CW-1:0]         t_sel;

  always_comb begin
    if (top_flags.hit && (!bot_flags.hit || (top_t < bot_t))) begin
      t_sel = top_t;
    end else if (bot_flags.hit) begin
      t_sel = bot_t;
    end else begin
      t_sel = '0;
    end
    out_dist_nxt = OUT_DIST_W'(t_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
    end else begin
      out_valid_r <= top_flags.valid;
      out_hit_r   <= top_flags.valid & (top_flags.hit | bot_flags.hit);
    end
  end

  always_ff @(posedge clk) begin
    out_dist_r <= out_dist_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_distance = out_dist_r;

`ifndef SYNTHESIS
  a_result_has_ray: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result beat without a matching ray beat");

  a_miss_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_distance == 0))
    else $error("miss reported with a nonzero distance");

  a_caps_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    top_flags.valid == bot_flags.valid)
    else $error("cap pipelines out of step");
`endif

endmodule
`default_nettype wire
